/* hdl/keyed_event_time_accumulator_assert.svh */
// Assertion helpers for the keyed event time accumulator.
`ifndef KEYED_EVENT_TIME_ACCUMULATOR_ASSERT_SVH
`define KEYED_EVENT_TIME_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KETA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keta: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KETA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keta: next-cycle check failed");

`endif

/* hdl/keta_pkg.sv */
package keta_pkg;

   localparam int KEY_W = 64;
   localparam int IDX_W = 8;

   // Result status codes
   typedef enum logic [2:0] {
      ST_UPDATED    = 3'd0,
      ST_INSERTED   = 3'd1,
      ST_FULL       = 3'd2,
      ST_NULL_KEY   = 3'd3,
      ST_READ_VALID = 3'd4,
      ST_READ_EMPTY = 3'd5
   } status_type;

   // Request opcodes
   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_READ       = 1'b1
   } opcode_type;

   // Engine sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_EMIT
   } state_type;

   // One table entry as held in memory
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] count;
      logic [KEY_W-1:0] total;
   } entry_type;

   // One result transaction
   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] entry_index;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] count;
      logic [KEY_W-1:0] total;
   } res_type;

endpackage

/* hdl/keta_channels.sv */
// Request channel: accumulate or read transactions.
interface keta_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [63:0] location_key;
   logic [63:0] elapsed_time;
   logic [7:0]  read_index;

   modport source (output valid, opcode, location_key, elapsed_time, read_index,
                   input ready);
   modport sink (input valid, opcode, location_key, elapsed_time, read_index,
                 output ready);
endinterface

// Response channel: one result per request.
interface keta_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  entry_index;
   logic [63:0] key_out;
   logic [63:0] event_count;
   logic [63:0] time_total;

   modport source (output valid, status, entry_index, key_out, event_count, time_total,
                   input ready);
   modport sink (input valid, status, entry_index, key_out, event_count, time_total,
                 output ready);
endinterface

/* hdl/keta_table.sv */
module keta_table
   import keta_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int IW    = 8
) (
   input  logic          clock,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/keta_engine.sv */
module keta_engine
   import keta_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int IW            = 8,
   parameter int FW            = 9
) (
   input  logic          clock,
   input  logic          reset,
   keta_req_if.sink      req,
   output logic [IW-1:0] rd_addr,
   input  entry_type     rd_data,
   output logic          wr_en,
   output logic [IW-1:0] wr_addr,
   output entry_type     wr_data,
   output logic          res_valid,
   input  logic          res_ready,
   output res_type       res,
   output logic          busy
);

   state_type        state_ff, state_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [63:0]      key_ff, key_in;
   logic [63:0]      dt_ff, dt_in;
   res_type          res_ff, res_in;

   logic             accept;
   logic             read_hit;
   logic             cur_last;
   logic             key_hit;
   logic             full;
   logic [IW-1:0]    fill_idx;

   // Status of the table and the current scan step
   assign accept   = req.valid && (state_ff == S_IDLE);
   assign read_hit = (FW+8)'(req.read_index) < (FW+8)'(fill_ff);
   assign cur_last = (FW'(cur_ff) + FW'(1)) == fill_ff;
   assign key_hit  = rd_data.key == key_ff;
   assign full     = fill_ff == FW'(TABLE_ENTRIES);
   assign fill_idx = fill_ff[IW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.opcode == OP_READ) begin
                  state_in = read_hit ? S_READ : S_EMIT;
               end else if (req.location_key == '0 || fill_ff == '0) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (key_hit || cur_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory accesses and result assembly
   always_comb begin
      rd_addr       = cur_ff + IW'(1);
      wr_en         = 1'b0;
      wr_addr       = fill_idx;
      wr_data.key   = key_ff;
      wr_data.count = 64'd1;
      wr_data.total = dt_ff;
      res_in        = res_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      key_in        = key_ff;
      dt_in         = dt_ff;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = (req.opcode == OP_READ) ? IW'(req.read_index) : '0;
            if (accept) begin
               key_in             = req.location_key;
               dt_in              = req.elapsed_time;
               cur_in             = '0;
               res_in.entry_index = '0;
               res_in.key         = '0;
               res_in.count       = '0;
               res_in.total       = '0;
               if (req.opcode == OP_READ) begin
                  res_in.entry_index = req.read_index;
                  res_in.status      = read_hit ? ST_READ_VALID : ST_READ_EMPTY;
               end else if (req.location_key == '0) begin
                  res_in.status = ST_NULL_KEY;
               end else if (fill_ff == '0) begin
                  // empty table: claim entry zero right away
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  wr_data.key   = req.location_key;
                  wr_data.total = req.elapsed_time;
                  fill_in       = FW'(1);
                  res_in.status = ST_INSERTED;
                  res_in.key    = req.location_key;
                  res_in.count  = 64'd1;
                  res_in.total  = req.elapsed_time;
               end
            end
         end
         S_READ: begin
            res_in.status = ST_READ_VALID;
            res_in.key    = rd_data.key;
            res_in.count  = rd_data.count;
            res_in.total  = rd_data.total;
         end
         S_SCAN: begin
            cur_in = cur_ff + IW'(1);
            if (key_hit) begin
               // existing entry: bump count, add time
               wr_en              = 1'b1;
               wr_addr            = cur_ff;
               wr_data.count      = rd_data.count + 64'd1;
               wr_data.total      = rd_data.total + dt_ff;
               res_in.status      = ST_UPDATED;
               res_in.entry_index = 8'(cur_ff);
               res_in.key         = key_ff;
               res_in.count       = rd_data.count + 64'd1;
               res_in.total       = rd_data.total + dt_ff;
            end else if (cur_last) begin
               if (full) begin
                  res_in.status = ST_FULL;
               end else begin
                  // key absent: claim the next free entry
                  wr_en              = 1'b1;
                  fill_in            = fill_ff + FW'(1);
                  res_in.status      = ST_INSERTED;
                  res_in.entry_index = 8'(fill_idx);
                  res_in.key         = key_ff;
                  res_in.count       = 64'd1;
                  res_in.total       = dt_ff;
               end
            end
         end
         S_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      key_ff <= key_in;
      dt_ff  <= dt_in;
      res_ff <= res_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;
   assign busy      = (state_ff != S_IDLE);

endmodule

/* hdl/keyed_event_time_accumulator.sv */
// Keyed event time accumulator: a profiling table of TABLE_ENTRIES entries, each
// holding a location key, an event count and a time total (both wrap at 2^64).
// Entries are claimed in order and never freed, so a fill count marks the used
// prefix; reset clears the count and no clearing pass is needed.
// One item is worked on at a time. A null-key accumulate, a read of an empty
// entry or an accumulate into an empty table goes straight to the result
// register; a read of a used entry first passes a read state. Another
// accumulate scans n entries (matching position plus one, or the fill count
// when the key is new); the table's single read port compares one entry per cycle.
// A finished result waits in an output register while the next item is taken.
`include "keyed_event_time_accumulator_assert.svh"

module keyed_event_time_accumulator
   import keta_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic      clock,
   input  logic      reset,
   keta_req_if.sink  req_bus,
   keta_rsp_if.source rsp_bus
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FW = $clog2(TABLE_ENTRIES + 1);

   logic [IW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic          res_valid;
   logic          res_ready;
   res_type       res;
   logic          busy;

   logic          rsp_valid_ff, rsp_valid_in;
   res_type       rsp_data_ff, rsp_data_in;

   keta_table #(
      .DEPTH (TABLE_ENTRIES),
      .IW    (IW)
   ) u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   keta_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IW            (IW),
      .FW            (FW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .busy      (busy)
   );

   // Output register between engine and response channel
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_data_ff.status;
   assign rsp_bus.entry_index = rsp_data_ff.entry_index;
   assign rsp_bus.key_out     = rsp_data_ff.key;
   assign rsp_bus.event_count = rsp_data_ff.count;
   assign rsp_bus.time_total  = rsp_data_ff.total;

   // Checks
   `KETA_ASSERT_NXT(a_accept_busy, clock, reset, req_bus.valid && req_bus.ready, busy)
   `KETA_ASSERT_IMP(a_result_busy, clock, reset, res_valid, busy && !req_bus.ready)
   `KETA_ASSERT_IMP(a_drop_zero, clock, reset,
      res_valid && (res.status == ST_FULL || res.status == ST_NULL_KEY),
      res.entry_index == '0 && res.key == '0 && res.count == '0 && res.total == '0)
   `KETA_ASSERT_IMP(a_touch_key, clock, reset,
      res_valid && (res.status == ST_UPDATED || res.status == ST_INSERTED),
      res.key != '0)

endmodule

/* tb/keyed_event_time_accumulator_checker.sv */
// Watches the request and response channels, keeps its own copy of the
// profiling table and compares every response with the predicted one.
module keyed_event_time_accumulator_checker
   import keta_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic clock,
   input  logic reset,
   keta_req_if  req_mon,
   keta_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_pending,
   output int   results_checked,
   output int   updates_seen,
   output int   inserts_seen,
   output int   drops_seen,
   output int   null_keys_seen,
   output int   reads_seen
);

   // Shadow table
   logic [KEY_W-1:0] held_keys   [TABLE_ENTRIES];
   logic [KEY_W-1:0] held_counts [TABLE_ENTRIES];
   logic [KEY_W-1:0] held_totals [TABLE_ENTRIES];

   // Responses still owed by the block, oldest first
   res_type owed_results[$];

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: response %0d, %s: expected %h, got %h",
               $time, results_checked, what, want, got);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want)
         report_mismatch(what, want, got);
   endtask

   // Applies one request to the shadow table and returns the response it owes
   function automatic res_type apply_sample(input logic op, input logic [63:0] key,
                                            input logic [63:0] dt,
                                            input logic [IDX_W-1:0] idx);
      res_type r;
      int slot;
      r = '0;
      slot = -1;
      if (opcode_type'(op) == OP_READ) begin
         r.entry_index = idx;
         if (int'(idx) < TABLE_ENTRIES && held_keys[idx] != '0) begin
            r.status = ST_READ_VALID;
            r.key    = held_keys[idx];
            r.count  = held_counts[idx];
            r.total  = held_totals[idx];
         end else begin
            r.status = ST_READ_EMPTY;
         end
      end else if (key == '0) begin
         r.status = ST_NULL_KEY;
      end else begin
         // first entry holding the key, or first empty one
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && (held_keys[i] == key || held_keys[i] == '0))
               slot = i;
         end
         if (slot < 0) begin
            r.status = ST_FULL;
         end else begin
            if (held_keys[slot] == key) begin
               r.status = ST_UPDATED;
            end else begin
               r.status = ST_INSERTED;
               held_keys[slot] = key;
            end
            held_counts[slot] = held_counts[slot] + 64'd1;
            held_totals[slot] = held_totals[slot] + dt;
            r.entry_index = IDX_W'(slot);
            r.key   = held_keys[slot];
            r.count = held_counts[slot];
            r.total = held_totals[slot];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         foreach (held_keys[i]) begin
            held_keys[i]   = '0;
            held_counts[i] = '0;
            held_totals[i] = '0;
         end
         owed_results.delete();
         fail_count      = 0;
         results_checked = 0;
         updates_seen    = 0;
         inserts_seen    = 0;
         drops_seen      = 0;
         null_keys_seen  = 0;
         reads_seen      = 0;
         results_pending <= 0;
      end else begin
         // Response side first: a response can never belong to this cycle's request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("response with none outstanding", '0,
                               64'(rsp_mon.status));
            end else begin
               want = owed_results.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_mon.status));
               check_field("entry_index", 64'(want.entry_index),
                           64'(rsp_mon.entry_index));
               check_field("key_out", want.key, rsp_mon.key_out);
               check_field("event_count", want.count, rsp_mon.event_count);
               check_field("time_total", want.total, rsp_mon.time_total);
               case (want.status)
                  ST_UPDATED:  updates_seen++;
                  ST_INSERTED: inserts_seen++;
                  ST_FULL:     drops_seen++;
                  ST_NULL_KEY: null_keys_seen++;
                  default:     reads_seen++;
               endcase
            end
            results_checked++;
         end
         if (req_mon.valid && req_mon.ready)
            owed_results.push_back(apply_sample(req_mon.opcode, req_mon.location_key,
                                                req_mon.elapsed_time,
                                                req_mon.read_index));
         results_pending <= owed_results.size();
      end
   end

endmodule

/* tb/keyed_event_time_accumulator_test.sv */
// Drives accumulate and read transactions into the profiling table, with
// bursty requests and a stalling response side, and gives the verdict.
module keyed_event_time_accumulator_test;
   import keta_pkg::*;

   localparam int TABLE_ENTRIES = 256;

   // Response ready patterns
   typedef enum int {
      RSP_OPEN,
      RSP_COIN,
      RSP_LONG_STALL,
      RSP_SPARSE
   } stall_style_type;

   logic clock;
   logic reset;

   keta_req_if req_bus ();
   keta_rsp_if rsp_bus ();

   int fail_count;
   int results_pending;
   int results_checked;
   int updates_seen;
   int inserts_seen;
   int drops_seen;
   int null_keys_seen;
   int reads_seen;

   int           burst_left;
   bit           gaps_on;
   logic [63:0]  key_pool [24];
   logic [63:0]  known_keys[$];

   keyed_event_time_accumulator #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   keyed_event_time_accumulator_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) table_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .updates_seen    (updates_seen),
      .inserts_seen    (inserts_seen),
      .drops_seen      (drops_seen),
      .null_keys_seen  (null_keys_seen),
      .reads_seen      (reads_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #40000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: stall style is picked anew at random intervals
   initial begin
      stall_style_type style;
      int style_left;
      int hold;
      style = RSP_OPEN;
      style_left = 0;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(50, 400);
            end
            style_left--;
            case (style)
               RSP_OPEN: rsp_bus.ready <= 1'b1;
               RSP_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               RSP_LONG_STALL: begin
                  if (hold > 0) begin
                     hold--;
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                     if ($urandom_range(0, 3) == 0)
                        hold = $urandom_range(1, 12);
                  end
               end
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Small, near-wrap and full-range elapsed times
   function automatic logic [63:0] random_time();
      logic [63:0] t;
      case ($urandom_range(0, 3))
         0:       t = 64'($urandom_range(0, 1000));
         1:       t = {32'hFFFF_FFFF, $urandom};
         default: t = {$urandom, $urandom};
      endcase
      return t;
   endfunction

   // Reads lean toward the used low part of the table
   function automatic logic [7:0] pick_index();
      logic [7:0] idx;
      if ($urandom_range(0, 1) == 0)
         idx = 8'($urandom_range(0, 40));
      else
         idx = 8'($urandom_range(0, 255));
      return idx;
   endfunction

   // One transaction; holds it until accepted, may idle between bursts when gaps are on
   task automatic send_item(input opcode_type op, input logic [63:0] key,
                            input logic [63:0] dt, input logic [7:0] idx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.location_key <= key;
      req_bus.elapsed_time <= dt;
      req_bus.read_index   <= idx;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_fresh_key();
      logic [63:0] key;
      key = random_key();
      known_keys.push_back(key);
      send_item(OP_ACCUMULATE, key, random_time(), 8'($urandom));
   endtask

   // Hold off until every owed response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   initial begin
      int pick;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_ACCUMULATE;
      req_bus.location_key <= '0;
      req_bus.elapsed_time <= '0;
      req_bus.read_index   <= '0;
      burst_left = 0;
      gaps_on = 1'b0;
      foreach (key_pool[i]) begin
         key_pool[i] = random_key();
         known_keys.push_back(key_pool[i]);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, null keys, wrapping totals, field extremes
      send_item(OP_READ, '0, '0, 8'd0);
      send_item(OP_ACCUMULATE, '0, 64'd12345, 8'd0);
      send_item(OP_ACCUMULATE, '0, '1, 8'hFF);
      send_item(OP_ACCUMULATE, '1, '1, 8'd0);
      send_item(OP_ACCUMULATE, '1, 64'd1, 8'd0);
      send_item(OP_ACCUMULATE, 64'd1, '0, 8'd0);
      send_item(OP_ACCUMULATE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 8'd0);
      send_item(OP_ACCUMULATE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 8'd0);
      send_item(OP_ACCUMULATE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'hAA);
      send_item(OP_ACCUMULATE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
      for (int i = 0; i < 6; i++)
         send_item(OP_READ, random_key(), random_time(), 8'(i));
      send_item(OP_READ, '1, '1, 8'hFF);
      send_item(OP_READ, '0, '0, 8'h80);
      send_item(OP_ACCUMULATE, 64'd1, '1, 8'd0);
      send_item(OP_ACCUMULATE, 64'h0000_0000_FFFF_FFFF, 64'd7, 8'hFF);
      send_item(OP_READ, '0, '0, 8'd1);
      send_item(OP_READ, '0, '0, 8'd5);
      wait_drained();

      // Mostly hits on a small key set, with nulls, reads and a few new keys
      gaps_on = 1'b1;
      for (int i = 0; i < 600; i++) begin
         if (i == 300)
            wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_item(OP_ACCUMULATE, key_pool[$urandom_range(0, 23)], random_time(),
                      8'($urandom));
         else if (pick < 65)
            send_item(OP_ACCUMULATE, '0, random_time(), 8'($urandom));
         else if (pick < 90)
            send_item(OP_READ, random_key(), random_time(), pick_index());
         else
            send_fresh_key();
      end
      wait_drained();

      // Fill the table until it overflows
      for (int i = 0; i < 300; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(OP_READ, random_key(), random_time(), 8'($urandom));
         else
            send_fresh_key();
      end
      wait_drained();

      // Full table: reads everywhere, updates deep in the table, drops, noise
      for (int i = 0; i < 700; i++) begin
         gaps_on = (i < 350);
         pick = $urandom_range(0, 99);
         if (pick < 35)
            send_item(OP_READ, random_key(), random_time(), 8'($urandom));
         else if (pick < 60)
            send_item(OP_ACCUMULATE, known_keys[$urandom_range(0, known_keys.size() - 1)],
                      random_time(), 8'($urandom));
         else if (pick < 75)
            send_item(OP_ACCUMULATE, key_pool[$urandom_range(0, 23)], random_time(),
                      8'($urandom));
         else if (pick < 85)
            send_fresh_key();
         else if (pick < 90)
            send_item(OP_ACCUMULATE, '0, random_time(), 8'($urandom));
         else
            send_item(opcode_type'($urandom_range(0, 1)), random_key(), random_time(),
                      8'($urandom));
      end
      wait_drained();
      repeat (300) @(posedge clock);

      $display("Checked %0d responses: %0d inserts, %0d updates, %0d drops on a full table,",
               results_checked, inserts_seen, updates_seen, drops_seen);
      $display("%0d null keys and %0d entry reads, under bursty requests and response stalls.",
               null_keys_seen, reads_seen);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
